/* sv/mvrb_pkg.sv */
// ----------------------------------------------------------------------------
// mvrb_pkg
// Shared types and constants of the mesh vertex ring builder.
// ----------------------------------------------------------------------------
package mvrb_pkg;

  localparam int VTX_W      = 12;
  localparam int NUM_VTX    = 4096;
  localparam int FAN_MAX    = 30;
  localparam int CNT_W      = 5;
  localparam int PAIR_DEPTH = NUM_VTX * FAN_MAX;
  localparam int PADR_W     = 17;
  localparam int VC_W       = 13;
  localparam int PAIR_W     = 2 * VTX_W;
  localparam logic [VC_W-1:0] VC_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RING  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_idx_t;

  typedef struct packed {
    kind_t            kind;
    logic             oor;
    logic [VTX_W-1:0] v0;
    logic [VTX_W-1:0] v1;
    logic [VTX_W-1:0] v2;
  } cmd_t;

  typedef struct packed {
    logic             push;
    cmd_t             cmd;
  } qwr_t;

  typedef struct packed {
    logic             pop;
    logic             full;
    logic             avail;
  } qctl_t;

  typedef struct packed {
    logic [VTX_W-1:0] neighbour;
    logic [CNT_W-1:0] ring_length;
    logic             cut_back;
    status_t          status;
    logic             last;
  } res_t;

  typedef enum logic [4:0] {
    BS_CLR, BS_IDLE, BS_RES,
    BS_L0, BS_L1, BS_L2, BS_L3, BS_LCHK, BS_LW0, BS_LW1, BS_LW2,
    BS_Q0, BS_Q1, BS_Q2, BS_FCHK, BS_FSRCH, BS_BSTART, BS_BSRCH, BS_BDONE,
    BS_EMIT
  } bstate_t;

  function automatic logic [PADR_W-1:0] mul_fan(input logic [VTX_W-1:0] v);
    mul_fan = {v, 5'b0} - {4'b0, v, 1'b0};
  endfunction

endpackage

/* sv/mvrb_if.sv */
// ----------------------------------------------------------------------------
// mvrb_in_if / mvrb_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface mvrb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] first_vertex;
  logic [11:0] second_vertex;
  logic [11:0] third_vertex;
  modport source (output valid, kind, first_vertex, second_vertex, third_vertex,
                  input ready);
  modport sink   (input valid, kind, first_vertex, second_vertex, third_vertex,
                  output ready);
endinterface

interface mvrb_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] neighbour;
  logic [4:0]  ring_length;
  logic        cut_back;
  logic [1:0]  status;
  logic        last;
  modport source (output valid, neighbour, ring_length, cut_back, status, last,
                  input ready);
  modport sink   (input valid, neighbour, ring_length, cut_back, status, last,
                  output ready);
endinterface

/* sv/mvrb_front.sv */
// ----------------------------------------------------------------------------
// mvrb_front
// Accepts command words, range-checks vertices, drops unused kinds.
// ----------------------------------------------------------------------------
module mvrb_front
  import mvrb_pkg::*;
(
  mvrb_in_if.sink          in_ch,
  input  logic [VC_W-1:0]  vertex_count,
  input  qctl_t            qctl,
  output qwr_t             qwr
);

  logic oor0, oor1, oor2;
  kind_t k;

  assign k    = kind_t'(in_ch.kind);
  assign oor0 = {1'b0, in_ch.first_vertex}  >= vertex_count;
  assign oor1 = {1'b0, in_ch.second_vertex} >= vertex_count;
  assign oor2 = {1'b0, in_ch.third_vertex}  >= vertex_count;

  assign in_ch.ready = !qctl.full;

  always_comb begin
    qwr.push    = in_ch.valid && !qctl.full && (k != KIND_NONE);
    qwr.cmd.kind = k;
    qwr.cmd.v0  = in_ch.first_vertex;
    qwr.cmd.v1  = in_ch.second_vertex;
    qwr.cmd.v2  = in_ch.third_vertex;
    unique case (k)
      KIND_LOAD:  qwr.cmd.oor = oor0 || oor1 || oor2;
      KIND_QUERY: qwr.cmd.oor = oor0;
      default:    qwr.cmd.oor = 1'b0;
    endcase
  end

endmodule

/* sv/mvrb_queue.sv */
// ----------------------------------------------------------------------------
// mvrb_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module mvrb_queue
  import mvrb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  qwr_t  qwr,
  input  logic  pop,
  output qctl_t qctl,
  output cmd_t  head
);

  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign qctl.full  = count == 2'd2;
  assign qctl.avail = count != 2'd0;
  assign qctl.pop   = pop;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (qwr.push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, qwr.push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      mem[wptr] <= qwr.cmd;
    end
  end

endmodule

/* sv/mvrb_back.sv */
// ----------------------------------------------------------------------------
// mvrb_back
// Executes loads, ring queries and clears on the fan count and pair memories.
// ----------------------------------------------------------------------------
module mvrb_back
  import mvrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  cmd_t        head,
  output logic        pop,
  output logic        sweeping,
  mvrb_out_if.source  out_ch
);

  logic [CNT_W-1:0]  fan_mem  [NUM_VTX];
  logic [PAIR_W-1:0] pair_mem [PAIR_DEPTH];
  logic [VTX_W-1:0]  ring     [32];

  bstate_t state, state_next;
  cmd_t cmd, cmd_next;
  logic [PADR_W-1:0] base, base_next;
  logic [CNT_W-1:0] cnt, cnt_next, expect_len, expect_len_next;
  logic [CNT_W-1:0] ci, ci_next, bi, bi_next, idx, idx_next, k, k_next;
  logic [CNT_W-1:0] fa, fa_next, fb, fb_next, fcc, fcc_next;
  logic [VTX_W-1:0] hd, hd_next, cur, cur_next;
  logic [VTX_W-1:0] sweep, sweep_next;
  logic clr_res, clr_res_next, rev, rev_next;
  res_t res, res_next;

  logic fc_we;
  logic [VTX_W-1:0] fc_wa, fc_ra;
  logic [CNT_W-1:0] fc_wd, fc_rd;
  logic pr_we;
  logic [PADR_W-1:0] pr_wa, pr_ra;
  logic [PAIR_W-1:0] pr_wd, pr_rd;
  logic ring_we;
  logic [CNT_W-1:0] ring_wa, ring_ra;
  logic [VTX_W-1:0] ring_wd;

  logic ovalid, out_free, out_push;
  res_t odata, opush;

  logic [VTX_W-1:0] lead, trail;
  logic [5:0] occ0, occ1, occ2, fin0, fin1, fin2;
  logic [CNT_W-1:0] pre1, pre2;

  assign lead  = pr_rd[PAIR_W-1:VTX_W];
  assign trail = pr_rd[VTX_W-1:0];
  assign out_free = !ovalid || out_ch.ready;
  assign sweeping = state == BS_CLR;

  assign occ0 = 6'd1 + {5'd0, cmd.v1 == cmd.v0} + {5'd0, cmd.v2 == cmd.v0};
  assign occ1 = 6'd1 + {5'd0, cmd.v0 == cmd.v1} + {5'd0, cmd.v2 == cmd.v1};
  assign occ2 = 6'd1 + {5'd0, cmd.v0 == cmd.v2} + {5'd0, cmd.v1 == cmd.v2};
  assign fin0 = {1'b0, fa}  + occ0;
  assign fin1 = {1'b0, fb}  + occ1;
  assign fin2 = {1'b0, fcc} + occ2;
  assign pre1 = fb + {4'd0, cmd.v0 == cmd.v1};
  assign pre2 = fcc + {4'd0, cmd.v0 == cmd.v2} + {4'd0, cmd.v1 == cmd.v2};

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    base_next = base;
    cnt_next = cnt;
    expect_len_next = expect_len;
    ci_next = ci;
    bi_next = bi;
    idx_next = idx;
    k_next = k;
    fa_next = fa;
    fb_next = fb;
    fcc_next = fcc;
    hd_next = hd;
    cur_next = cur;
    sweep_next = sweep;
    clr_res_next = clr_res;
    rev_next = rev;
    res_next = res;
    pop = 1'b0;
    fc_we = 1'b0;
    fc_wa = sweep;
    fc_wd = '0;
    fc_ra = cmd.v0;
    pr_we = 1'b0;
    pr_wa = base;
    pr_wd = '0;
    pr_ra = base;
    ring_we = 1'b0;
    ring_wa = ci;
    ring_wd = cur;
    ring_ra = rev ? ci - 5'd1 - k : k;
    out_push = 1'b0;
    opush = res;
    unique case (state)
      BS_CLR: begin
        fc_we = 1'b1;
        sweep_next = sweep + 1'b1;
        if (sweep == VTX_W'(NUM_VTX - 1)) begin
          res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b0,
                       status: ST_OK, last: 1'b1};
          state_next = clr_res ? BS_RES : BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          cmd_next = head;
          res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b0,
                       status: ST_RANGE, last: 1'b1};
          unique case (head.kind)
            KIND_LOAD:  state_next = head.oor ? BS_RES : BS_L0;
            KIND_QUERY: state_next = head.oor ? BS_RES : BS_Q0;
            KIND_CLEAR: begin
              sweep_next = '0;
              clr_res_next = 1'b1;
              state_next = BS_CLR;
            end
            default: state_next = BS_IDLE;
          endcase
        end
      end
      BS_RES: begin
        if (out_free) begin
          out_push = 1'b1;
          state_next = BS_IDLE;
        end
      end
      BS_L0: begin
        fc_ra = cmd.v0;
        state_next = BS_L1;
      end
      BS_L1: begin
        fa_next = fc_rd;
        fc_ra = cmd.v1;
        state_next = BS_L2;
      end
      BS_L2: begin
        fb_next = fc_rd;
        fc_ra = cmd.v2;
        state_next = BS_L3;
      end
      BS_L3: begin
        fcc_next = fc_rd;
        state_next = BS_LCHK;
      end
      BS_LCHK: begin
        if (fin0 > 6'(FAN_MAX) || fin1 > 6'(FAN_MAX) || fin2 > 6'(FAN_MAX)) begin
          res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b0,
                       status: ST_FULL, last: 1'b1};
          state_next = BS_RES;
        end else begin
          state_next = BS_LW0;
        end
      end
      BS_LW0: begin
        pr_we = 1'b1;
        pr_wa = mul_fan(cmd.v0) + {12'd0, fa};
        pr_wd = {cmd.v1, cmd.v2};
        fc_we = 1'b1;
        fc_wa = cmd.v0;
        fc_wd = fin0[CNT_W-1:0];
        state_next = BS_LW1;
      end
      BS_LW1: begin
        pr_we = 1'b1;
        pr_wa = mul_fan(cmd.v1) + {12'd0, pre1};
        pr_wd = {cmd.v2, cmd.v0};
        fc_we = 1'b1;
        fc_wa = cmd.v1;
        fc_wd = fin1[CNT_W-1:0];
        state_next = BS_LW2;
      end
      BS_LW2: begin
        pr_we = 1'b1;
        pr_wa = mul_fan(cmd.v2) + {12'd0, pre2};
        pr_wd = {cmd.v0, cmd.v1};
        fc_we = 1'b1;
        fc_wa = cmd.v2;
        fc_wd = fin2[CNT_W-1:0];
        res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b0,
                     status: ST_OK, last: 1'b1};
        state_next = BS_RES;
      end
      BS_Q0: begin
        fc_ra = cmd.v0;
        base_next = mul_fan(cmd.v0);
        state_next = BS_Q1;
      end
      BS_Q1: begin
        cnt_next = fc_rd;
        expect_len_next = (fc_rd == 5'd1) ? 5'd2 : fc_rd;
        pr_ra = base;
        if (fc_rd == '0) begin
          res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b1,
                       status: ST_OK, last: 1'b1};
          state_next = BS_RES;
        end else begin
          state_next = BS_Q2;
        end
      end
      BS_Q2: begin
        hd_next = lead;
        cur_next = trail;
        ring_we = 1'b1;
        ring_wa = '0;
        ring_wd = lead;
        ci_next = 5'd1;
        state_next = BS_FCHK;
      end
      BS_FCHK: begin
        if (cur == hd) begin
          k_next = '0;
          rev_next = 1'b0;
          state_next = BS_EMIT;
        end else begin
          ring_we = 1'b1;
          ring_wa = ci;
          ring_wd = cur;
          idx_next = '0;
          pr_ra = base;
          state_next = BS_FSRCH;
        end
      end
      BS_FSRCH: begin
        pr_ra = base + {12'd0, idx + 5'd1};
        if (lead == cur) begin
          cur_next = trail;
          ci_next = ci + 5'd1;
          state_next = ((ci + 5'd1) > expect_len) ? BS_BSTART : BS_FCHK;
        end else if ({1'b0, idx} + 6'd1 < {1'b0, cnt}) begin
          idx_next = idx + 5'd1;
        end else begin
          state_next = BS_BSTART;
        end
      end
      BS_BSTART: begin
        expect_len_next = cnt + 5'd1;
        ring_we = 1'b1;
        ring_wa = '0;
        ring_wd = cur;
        bi_next = 5'd1;
        idx_next = '0;
        pr_ra = base;
        state_next = BS_BSRCH;
      end
      BS_BSRCH: begin
        pr_ra = base + {12'd0, idx + 5'd1};
        if (trail == cur) begin
          cur_next = lead;
          ring_we = 1'b1;
          ring_wa = bi;
          ring_wd = lead;
          bi_next = bi + 5'd1;
          idx_next = '0;
          pr_ra = base;
          if (bi + 5'd1 >= 5'(FAN_MAX)) begin
            state_next = BS_BDONE;
          end
        end else if ({1'b0, idx} + 6'd1 < {1'b0, cnt}) begin
          idx_next = idx + 5'd1;
        end else begin
          state_next = BS_BDONE;
        end
      end
      BS_BDONE: begin
        if (bi != expect_len) begin
          res_next = '{neighbour: '0, ring_length: '0, cut_back: 1'b1,
                       status: ST_RING, last: 1'b1};
          state_next = BS_RES;
        end else begin
          ci_next = bi;
          rev_next = 1'b1;
          k_next = '0;
          state_next = BS_EMIT;
        end
      end
      BS_EMIT: begin
        opush = '{neighbour: ring[ring_ra], ring_length: ci,
                  cut_back: ci != expect_len, status: ST_OK,
                  last: (k + 5'd1) == ci};
        if (out_free) begin
          out_push = 1'b1;
          k_next = k + 5'd1;
          if ((k + 5'd1) == ci) begin
            state_next = BS_IDLE;
          end
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BS_CLR;
      sweep   <= '0;
      clr_res <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      sweep   <= sweep_next;
      clr_res <= (state_next == BS_CLR) ? clr_res_next : 1'b0;
      if (out_push) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    base <= base_next;
    cnt <= cnt_next;
    expect_len <= expect_len_next;
    ci <= ci_next;
    bi <= bi_next;
    idx <= idx_next;
    k <= k_next;
    fa <= fa_next;
    fb <= fb_next;
    fcc <= fcc_next;
    hd <= hd_next;
    cur <= cur_next;
    rev <= rev_next;
    res <= res_next;
    if (out_push) begin
      odata <= opush;
    end
    if (ring_we) begin
      ring[ring_wa] <= ring_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (fc_we) begin
      fan_mem[fc_wa] <= fc_wd;
    end
    fc_rd <= fan_mem[fc_ra];
  end

  always_ff @(posedge clk) begin
    if (pr_we) begin
      pair_mem[pr_wa] <= pr_wd;
    end
    pr_rd <= pair_mem[pr_ra];
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.neighbour   = odata.neighbour;
  assign out_ch.ring_length = odata.ring_length;
  assign out_ch.cut_back    = odata.cut_back;
  assign out_ch.status      = odata.status;
  assign out_ch.last        = odata.last;

endmodule

/* sv/mesh_vertex_ring_builder_unit.sv */
// ----------------------------------------------------------------------------
// mesh_vertex_ring_builder_unit
// Builds ordered one-ring neighbour lists from loaded mesh triangles.
//
//   channel  dir  words
//   in_ch    in   kind, first/second/third_vertex
//   out_ch   out  neighbour, ring_length, cut_back, status, last
//   apb      in   vertex_count at address 0
//
// Load: reads three fan counts, checks, writes three pairs and counts, then
// one result word. Query: each pair search one pair-memory read a cycle,
// then one neighbour per cycle while out_ch is not stalled. Clear and reset:
// a sweep of all 4096 fan counts, during which no word is taken from the
// queue. Output register and a two-word queue decouple both sides.
// ----------------------------------------------------------------------------
module mesh_vertex_ring_builder_unit
  import mvrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mvrb_in_if.sink     in_ch,
  mvrb_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VC_W-1:0] vertex_count;
  qwr_t  qwr;
  qctl_t qctl;
  cmd_t  qhead;
  logic  pop, sweeping;

  assign pready = 1'b1;
  assign prdata = {{(32-VC_W){1'b0}}, vertex_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  mvrb_front u_front (
    .in_ch        (in_ch),
    .vertex_count (vertex_count),
    .qctl         (qctl),
    .qwr          (qwr)
  );

  mvrb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .qwr  (qwr),
    .pop  (pop),
    .qctl (qctl),
    .head (qhead)
  );

  mvrb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (qctl.avail),
    .head     (qhead),
    .pop      (pop),
    .sweeping (sweeping),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (rst)
    qctl.pop |-> !sweeping && qctl.avail)
    else $error("queue popped during sweep or while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qwr.push |-> !qctl.full)
    else $error("queue overflow");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.ring_length == '0 && out_ch.neighbour == '0 && out_ch.last)
    else $error("error word carries ring data");
`endif

endmodule
